[src/mkq_pkg.sv]
// ----------------------------------------------------------------------------
// mkq_pkg
// Shared types and constants for the Morse key timing qualifier.
// ----------------------------------------------------------------------------
`default_nettype none

package mkq_pkg;

	localparam int CFG_W          = 16;
	localparam int TIMER_BITS_DEF = 16;
	localparam int IDX_W          = 3;
	localparam int IN_W           = 8;
	localparam int OUT_W          = 8;

	// Register indexes of the configuration channel.
	localparam logic [IDX_W-1:0] REG_DEBOUNCE   = 3'd0;
	localparam logic [IDX_W-1:0] REG_DASH       = 3'd1;
	localparam logic [IDX_W-1:0] REG_LETTER_GAP = 3'd2;
	localparam logic [IDX_W-1:0] REG_WORD_GAP   = 3'd3;
	localparam logic [IDX_W-1:0] REG_LONG_HOLD  = 3'd4;

	localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
	localparam logic [CFG_W-1:0] DASH_RST       = 16'd400;
	localparam logic [CFG_W-1:0] LETTER_GAP_RST = 16'd600;
	localparam logic [CFG_W-1:0] WORD_GAP_RST   = 16'd1400;
	localparam logic [CFG_W-1:0] LONG_HOLD_RST  = 16'd1000;

	typedef struct packed {
		logic [CFG_W-1:0] debounce_ticks;
		logic [CFG_W-1:0] dash_threshold;
		logic [CFG_W-1:0] letter_gap_ticks;
		logic [CFG_W-1:0] word_gap_ticks;
		logic [CFG_W-1:0] long_hold_ticks;
	} cfg_t;

	// Debounce status of one button for the tick being processed.
	typedef struct packed {
		logic stable_old;
		logic stable_new;
		logic changed;
	} db_t;

	// Last member sits in the lowest bit, so this maps straight onto tdata.
	typedef struct packed {
		logic clear_event;
		logic play_request;
		logic print_request;
		logic word_gap;
		logic letter_gap;
		logic symbol_dash;
		logic symbol_valid;
		logic key_down;
	} result_t;

endpackage

`default_nettype wire

[src/mkq_cfg.sv]
// ----------------------------------------------------------------------------
// mkq_cfg
// Configuration register file written through its own valid/ready channel.
// ----------------------------------------------------------------------------
`default_nettype none

module mkq_cfg import mkq_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t regs_q;

	assign cfg_ready = 1'b1;
	assign cfg       = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.debounce_ticks   <= DEBOUNCE_RST;
			regs_q.dash_threshold   <= DASH_RST;
			regs_q.letter_gap_ticks <= LETTER_GAP_RST;
			regs_q.word_gap_ticks   <= WORD_GAP_RST;
			regs_q.long_hold_ticks  <= LONG_HOLD_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DEBOUNCE:   regs_q.debounce_ticks   <= cfg_data;
				REG_DASH:       regs_q.dash_threshold   <= cfg_data;
				REG_LETTER_GAP: regs_q.letter_gap_ticks <= cfg_data;
				REG_WORD_GAP:   regs_q.word_gap_ticks   <= cfg_data;
				REG_LONG_HOLD:  regs_q.long_hold_ticks  <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

[src/mkq_debounce.sv]
// ----------------------------------------------------------------------------
// mkq_debounce
// Debouncer for one active-low button, advanced once per accepted tick.
// ----------------------------------------------------------------------------
`default_nettype none

module mkq_debounce import mkq_pkg::*; #(
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             raw,
	input  wire logic [CFG_W-1:0] thr,
	output db_t                   st
);

	localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

	logic [TIMER_BITS-1:0] count_q;
	logic [TIMER_BITS-1:0] count_d;
	logic                  last_q;
	logic                  stable_q;
	logic                  take;

	always_comb begin
		if (raw != last_q)
			count_d = '0;
		else if (&count_q)
			count_d = count_q;
		else
			count_d = count_q + 1'b1;
		take = (CMP_W'(count_d) > CMP_W'(thr)) && (raw != stable_q);
	end

	assign st.stable_old = stable_q;
	assign st.stable_new = take ? raw : stable_q;
	assign st.changed    = take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			last_q   <= 1'b1;
			stable_q <= 1'b1;
		end else if (en) begin
			count_q  <= count_d;
			last_q   <= raw;
			stable_q <= st.stable_new;
		end
	end

endmodule

`default_nettype wire

[src/mkq_events.sv]
// ----------------------------------------------------------------------------
// mkq_events
// Press, release and hold timers, symbol and gap detection, and the
// print and play/clear requests for one tick.
// ----------------------------------------------------------------------------
`default_nettype none

module mkq_events import mkq_pkg::*; #(
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire cfg_t cfg,
	input  wire db_t  key,
	input  wire db_t  prn,
	input  wire db_t  ply,
	output result_t   res
);

	localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

	logic [TIMER_BITS-1:0] press_q, release_q, hold_q;
	logic                  ldone_q, wdone_q, have_q;

	logic [TIMER_BITS-1:0] press_inc, release_inc, hold_inc;
	logic [TIMER_BITS-1:0] press_d, release_d, hold_d;
	logic                  ldone_d, wdone_d, have_d;

	always_comb begin
		press_inc   = press_q;
		release_inc = release_q;
		hold_inc    = hold_q;
		if (!key.stable_old && !(&press_q))
			press_inc = press_q + 1'b1;
		if (key.stable_old && !(&release_q))
			release_inc = release_q + 1'b1;
		if (!ply.stable_old && !(&hold_q))
			hold_inc = hold_q + 1'b1;

		press_d   = press_inc;
		release_d = release_inc;
		hold_d    = hold_inc;
		ldone_d   = ldone_q;
		wdone_d   = wdone_q;
		have_d    = have_q;
		res       = '0;

		if (key.changed) begin
			if (!key.stable_new) begin
				press_d = '0;
				ldone_d = 1'b0;
				wdone_d = 1'b0;
			end else begin
				release_d        = '0;
				res.symbol_valid = 1'b1;
				res.symbol_dash  = CMP_W'(press_inc) >= CMP_W'(cfg.dash_threshold);
				have_d           = 1'b1;
			end
		end

		// Gaps are only flagged while the key rests and symbols are stored.
		if (key.stable_new && have_d) begin
			if (CMP_W'(release_d) >= CMP_W'(cfg.letter_gap_ticks) && !ldone_d) begin
				res.letter_gap = 1'b1;
				ldone_d        = 1'b1;
			end
			if (CMP_W'(release_d) >= CMP_W'(cfg.word_gap_ticks) && !wdone_d) begin
				res.word_gap = 1'b1;
				wdone_d      = 1'b1;
			end
		end

		res.print_request = prn.changed && !prn.stable_new;

		if (ply.changed) begin
			if (!ply.stable_new) begin
				hold_d = '0;
			end else if (CMP_W'(hold_inc) >= CMP_W'(cfg.long_hold_ticks)) begin
				res.clear_event = 1'b1;
				have_d          = 1'b0;
				ldone_d         = 1'b0;
				wdone_d         = 1'b0;
			end else begin
				res.play_request = 1'b1;
			end
		end

		res.key_down = !key.stable_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_q   <= '0;
			release_q <= '0;
			hold_q    <= '0;
			ldone_q   <= 1'b0;
			wdone_q   <= 1'b0;
			have_q    <= 1'b0;
		end else if (en) begin
			press_q   <= press_d;
			release_q <= release_d;
			hold_q    <= hold_d;
			ldone_q   <= ldone_d;
			wdone_q   <= wdone_d;
			have_q    <= have_d;
		end
	end

endmodule

`default_nettype wire

[src/morse_key_timing_qualifier.sv]
// ----------------------------------------------------------------------------
// morse_key_timing_qualifier
// Debounces a Morse key and two buttons, one tick per word, and reports
// symbols, gaps and button requests.
// ----------------------------------------------------------------------------
// The result of a tick is in the output register in the cycle after the
// input word is accepted. Throughput: one word per cycle while not stalled;
// the output register lets a new word in whenever it is empty or being drained.
// Reset clears all timers, counters and flags, sets the debounced levels
// to released and loads the register defaults.
`default_nettype none

module morse_key_timing_qualifier import mkq_pkg::*; #(
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_axis_tvalid,
	output logic                  s_axis_tready,
	// [0] key_level, [1] print_level, [2] play_level, [7:3] zero
	input  wire logic [IN_W-1:0]  s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  wire logic             m_axis_tready,
	// [0] key_down, [1] symbol_valid, [2] symbol_dash, [3] letter_gap,
	// [4] word_gap, [5] print_request, [6] play_request, [7] clear_event
	output logic [OUT_W-1:0]      m_axis_tdata,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data
);

	cfg_t    cfg;
	db_t     key_st, prn_st, ply_st;
	result_t res;
	result_t res_q;
	logic    out_valid_q;
	logic    accept;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = res_q;

	mkq_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mkq_debounce #(.TIMER_BITS(TIMER_BITS)) u_db_key (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (accept),
		.raw    (s_axis_tdata[0]),
		.thr    (cfg.debounce_ticks),
		.st     (key_st)
	);

	mkq_debounce #(.TIMER_BITS(TIMER_BITS)) u_db_print (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (accept),
		.raw    (s_axis_tdata[1]),
		.thr    (cfg.debounce_ticks),
		.st     (prn_st)
	);

	mkq_debounce #(.TIMER_BITS(TIMER_BITS)) u_db_play (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (accept),
		.raw    (s_axis_tdata[2]),
		.thr    (cfg.debounce_ticks),
		.st     (ply_st)
	);

	mkq_events #(.TIMER_BITS(TIMER_BITS)) u_events (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (accept),
		.cfg    (cfg),
		.key    (key_st),
		.prn    (prn_st),
		.ply    (ply_st),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the Morse key timing qualifier. A scoreboard class predicts
// the result word of every accepted tick and checks each result word,
// field by field, in order. The stimulus runs through several register
// settings: defaults, a short directed sequence, extremes, random small
// settings, and a debounce setting at the count's maximum under which no
// level change is ever accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mkq_pkg::*;

	localparam int BTN_KEY   = 0;
	localparam int BTN_PRINT = 1;
	localparam int BTN_PLAY  = 2;
	localparam int TW        = TIMER_BITS_DEF;

	// Levels per tick: [0] key, [1] print, [2] play; 1 is released.
	localparam logic [2:0] DIRECTED_LEVELS [31] = '{
		3'd6, 3'd6, 3'd7, 3'd7,
		3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd7, 3'd7,
		3'd7, 3'd7, 3'd7, 3'd7,
		3'd5, 3'd5, 3'd7, 3'd7,
		3'd3, 3'd3, 3'd7, 3'd7,
		3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd7, 3'd7
	};

	class tick_scoreboard;
		cfg_t          regs;
		logic [2:0]    last_raw;
		logic [2:0]    stable;
		logic [TW-1:0] settle_cnt [3];
		logic [TW-1:0] press_time;
		logic [TW-1:0] release_time;
		logic [TW-1:0] hold_time;
		bit            letter_done;
		bit            word_done;
		bit            have_symbols;
		result_t       expected_ticks [$];
		int            errors;

		function new();
			regs.debounce_ticks   = DEBOUNCE_RST;
			regs.dash_threshold   = DASH_RST;
			regs.letter_gap_ticks = LETTER_GAP_RST;
			regs.word_gap_ticks   = WORD_GAP_RST;
			regs.long_hold_ticks  = LONG_HOLD_RST;
			last_raw     = '1;
			stable       = '1;
			foreach (settle_cnt[b])
				settle_cnt[b] = '0;
			press_time   = '0;
			release_time = '0;
			hold_time    = '0;
			letter_done  = 0;
			word_done    = 0;
			have_symbols = 0;
			errors       = 0;
		endfunction

		function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			case (idx)
				REG_DEBOUNCE:   regs.debounce_ticks   = val;
				REG_DASH:       regs.dash_threshold   = val;
				REG_LETTER_GAP: regs.letter_gap_ticks = val;
				REG_WORD_GAP:   regs.word_gap_ticks   = val;
				REG_LONG_HOLD:  regs.long_hold_ticks  = val;
				default: ;
			endcase
		endfunction

		function logic [TW-1:0] sat_up(logic [TW-1:0] v);
			return (&v) ? v : v + 1'b1;
		endfunction

		// Returns 1 when the debounced level of the button flips this tick.
		function bit settle(int b, logic raw);
			if (raw != last_raw[b])
				settle_cnt[b] = '0;
			else
				settle_cnt[b] = sat_up(settle_cnt[b]);
			last_raw[b] = raw;
			if (settle_cnt[b] > regs.debounce_ticks && raw != stable[b]) begin
				stable[b] = raw;
				return 1;
			end
			return 0;
		endfunction

		function void note_tick(logic [IN_W-1:0] word);
			result_t r;
			r = '0;
			if (!stable[BTN_KEY])
				press_time = sat_up(press_time);
			else
				release_time = sat_up(release_time);
			if (!stable[BTN_PLAY])
				hold_time = sat_up(hold_time);

			if (settle(BTN_KEY, word[BTN_KEY])) begin
				if (!stable[BTN_KEY]) begin
					press_time  = '0;
					letter_done = 0;
					word_done   = 0;
				end else begin
					release_time   = '0;
					r.symbol_valid = 1'b1;
					r.symbol_dash  = (press_time >= regs.dash_threshold);
					have_symbols   = 1;
				end
			end

			if (stable[BTN_KEY] && have_symbols) begin
				if (release_time >= regs.letter_gap_ticks && !letter_done) begin
					r.letter_gap = 1'b1;
					letter_done  = 1;
				end
				if (release_time >= regs.word_gap_ticks && !word_done) begin
					r.word_gap = 1'b1;
					word_done  = 1;
				end
			end

			if (settle(BTN_PRINT, word[BTN_PRINT]) && !stable[BTN_PRINT])
				r.print_request = 1'b1;

			if (settle(BTN_PLAY, word[BTN_PLAY])) begin
				if (!stable[BTN_PLAY]) begin
					hold_time = '0;
				end else if (hold_time >= regs.long_hold_ticks) begin
					r.clear_event = 1'b1;
					have_symbols  = 0;
					letter_done   = 0;
					word_done     = 0;
				end else begin
					r.play_request = 1'b1;
				end
			end

			r.key_down = !stable[BTN_KEY];
			expected_ticks.push_back(r);
		endfunction

		function void check_field(string name, logic e, logic a);
			if (e !== a) begin
				$error("%s: expected %0b, got %0b", name, e, a);
				errors++;
			end
		endfunction

		function void check_result(logic [OUT_W-1:0] word);
			result_t act;
			result_t exp_r;
			act = word;
			if (expected_ticks.size() == 0) begin
				$error("result word %02h arrived with nothing expected", word);
				errors++;
				return;
			end
			exp_r = expected_ticks.pop_front();
			check_field("key_down", exp_r.key_down, act.key_down);
			check_field("symbol_valid", exp_r.symbol_valid, act.symbol_valid);
			check_field("symbol_dash", exp_r.symbol_dash, act.symbol_dash);
			check_field("letter_gap", exp_r.letter_gap, act.letter_gap);
			check_field("word_gap", exp_r.word_gap, act.word_gap);
			check_field("print_request", exp_r.print_request, act.print_request);
			check_field("play_request", exp_r.play_request, act.play_request);
			check_field("clear_event", exp_r.clear_event, act.clear_event);
		endfunction

		function int pending();
			return expected_ticks.size();
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata = '1;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	tick_scoreboard sb;
	cfg_t           cur_cfg;
	bit             idling_on = 1;
	bit             hold_off_req = 0;

	morse_key_timing_qualifier dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			sb.note_tick(s_axis_tdata);
		if (m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
		if (cfg_valid && cfg_ready)
			sb.write_reg(cfg_index, cfg_data);
	end

	// Result side: random stall bursts, plus one long hold-off on request.
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (stall_left == 0 && hold_off_req) begin
				stall_left   = 300;
				hold_off_req = 0;
			end else if (stall_left == 0 && idling_on && $urandom_range(0, 15) == 0) begin
				stall_left = $urandom_range(1, 10);
			end
			if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		#40_000_000;
		$display("tb_top: FAIL");
		$finish;
	end

	// Leaves tvalid high after the handshake; wait_drained lowers it.
	task automatic send_tick(input logic [2:0] lv);
		if (idling_on && $urandom_range(0, 7) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(IN_W-3){1'b0}}, lv};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic hold_levels(input logic [2:0] lv, input int n);
		repeat (n) send_tick(lv);
	endtask

	// Waits for the scoreboard to note the last accepted tick before checking that nothing is pending.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic put_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Writes every register, then an index that maps to no register.
	task automatic apply_config(input cfg_t c);
		logic [IDX_W-1:0] bad_idx;
		bad_idx = IDX_W'($urandom_range(REG_LONG_HOLD + 1, (1 << IDX_W) - 1));
		put_reg(REG_DEBOUNCE, c.debounce_ticks);
		put_reg(REG_DASH, c.dash_threshold);
		put_reg(REG_LETTER_GAP, c.letter_gap_ticks);
		put_reg(REG_WORD_GAP, c.word_gap_ticks);
		put_reg(REG_LONG_HOLD, c.long_hold_ticks);
		put_reg(bad_idx, CFG_W'($urandom));
		cfg_valid <= 1'b0;
		cur_cfg = c;
		@(posedge clk);
	endtask

	function automatic cfg_t random_small_cfg();
		cfg_t c;
		c.debounce_ticks   = CFG_W'($urandom_range(0, 6));
		c.dash_threshold   = CFG_W'($urandom_range(0, 30));
		c.letter_gap_ticks = CFG_W'($urandom_range(0, 40));
		c.word_gap_ticks   = CFG_W'($urandom_range(0, 60));
		c.long_hold_ticks  = CFG_W'($urandom_range(0, 40));
		return c;
	endfunction

	function automatic int cap_run(int v);
		return (v > 80) ? 80 : v;
	endfunction

	// Each button toggles after runs that mostly outlast the debounce count and reach past
	// the thresholds unless the run limit's cap of 80 cuts them short; one run in five is a short glitch.
	task automatic run_random(input int n, input int pressure_at);
		logic [2:0] lv;
		int         run_left [3];
		int         lim [3];
		int         db;
		db = int'(cur_cfg.debounce_ticks);
		lim[BTN_KEY] = cap_run(((cur_cfg.dash_threshold > cur_cfg.word_gap_ticks) ?
			cur_cfg.dash_threshold : cur_cfg.word_gap_ticks) + 8);
		lim[BTN_PRINT] = 8;
		lim[BTN_PLAY]  = cap_run(cur_cfg.long_hold_ticks + 8);
		lv = 3'b111;
		foreach (run_left[b])
			run_left[b] = $urandom_range(0, 4);
		for (int i = 0; i < n; i++) begin
			for (int b = 0; b < 3; b++) begin
				if (run_left[b] == 0) begin
					lv[b] = ~lv[b];
					if ($urandom_range(0, 4) == 0)
						run_left[b] = $urandom_range(1, db + 1);
					else
						run_left[b] = $urandom_range(db + 2, db + 2 + lim[b]);
				end
				run_left[b]--;
			end
			if (i == pressure_at)
				hold_off_req = 1;
			send_tick(lv);
		end
		wait_drained();
	endtask

	initial begin
		cfg_t c;
		sb = new();
		cur_cfg.debounce_ticks   = DEBOUNCE_RST;
		cur_cfg.dash_threshold   = DASH_RST;
		cur_cfg.letter_gap_ticks = LETTER_GAP_RST;
		cur_cfg.word_gap_ticks   = WORD_GAP_RST;
		cur_cfg.long_hold_ticks  = LONG_HOLD_RST;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Register defaults straight out of reset.
		run_random(150, -1);

		c.debounce_ticks   = 16'd0;
		c.dash_threshold   = 16'd3;
		c.letter_gap_ticks = 16'd2;
		c.word_gap_ticks   = 16'd4;
		c.long_hold_ticks  = 16'd4;
		apply_config(c);
		foreach (DIRECTED_LEVELS[i])
			send_tick(DIRECTED_LEVELS[i]);
		wait_drained();

		// Every press a dash, gaps in the release tick, every play a clear.
		c = '0;
		apply_config(c);
		run_random(150, -1);

		// Every press a dot, no gaps, no clears.
		c = '1;
		c.debounce_ticks = CFG_W'($urandom_range(0, 3));
		apply_config(c);
		run_random(150, -1);

		for (int p = 0; p < 4; p++) begin
			apply_config(random_small_cfg());
			run_random(150, (p == 0) ? 60 : -1);
		end

		// Debounce setting at the count's maximum: no level change is accepted.
		c = random_small_cfg();
		c.debounce_ticks = '1;
		apply_config(c);
		hold_levels(3'b000, 20);
		hold_levels(3'b111, 4);
		wait_drained();

		idling_on = 0;
		apply_config(random_small_cfg());
		run_random(150, -1);

		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

`default_nettype wire
